[rtl/ksoc_pkg.sv]
// Shared types, constants and the key lookup table for the keypad scan
// offset calibrator. No dependencies.
package ksoc_pkg;

  // Digit entry limit and the width of the digit counter it implies
  localparam int MAX_DIGITS  = 3;
  localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

  // Field widths
  localparam int ROW_W    = 4;
  localparam int SAMPLE_W = 10;
  localparam int CODE_W   = 4;
  localparam int VALUE_W  = 10;
  localparam int TEMP_W   = 12;
  localparam int DEB_W    = 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_DEBOUNCE_TICKS = 1'b0;
  localparam logic REG_ZERO_CODE      = 1'b1;

  localparam logic [DEB_W-1:0]    DEBOUNCE_RESET  = 8'd20;
  localparam logic [SAMPLE_W-1:0] ZERO_CODE_RESET = 10'd94;

  // Key codes
  localparam logic [CODE_W-1:0] KEY_STAR = 4'd10;
  localparam logic [CODE_W-1:0] KEY_HASH = 4'd11;
  localparam logic [CODE_W-1:0] KEY_NONE = 4'd0;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd1023;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } key_event_t;

  // Keypad layout: row 0 = 1 2 3, row 1 = 4 5 6, row 2 = 7 8 9, row 3 = * 0 #
  function automatic logic [CODE_W-1:0] key_lookup(input logic [1:0] row,
                                                   input logic [1:0] col);
    logic [CODE_W-1:0] code;
    case ({row, col})
      4'b00_00: code = 4'd1;
      4'b00_01: code = 4'd2;
      4'b00_10: code = 4'd3;
      4'b01_00: code = 4'd4;
      4'b01_01: code = 4'd5;
      4'b01_10: code = 4'd6;
      4'b10_00: code = 4'd7;
      4'b10_01: code = 4'd8;
      4'b10_10: code = 4'd9;
      4'b11_00: code = KEY_STAR;
      4'b11_01: code = 4'd0;
      4'b11_10: code = KEY_HASH;
      default:  code = KEY_NONE;
    endcase
    return code;
  endfunction

endpackage

[rtl/keypad_scan_offset_calibrator_core.sv]
// Top level of the keypad scan offset calibrator: configuration registers,
// input register, result register and handshakes.
// Depends on ksoc_pkg, ksoc_key_scan and ksoc_entry.
//
// Usage
//   Input channel (in_valid / in_stall): one transaction per timer tick,
//   carrying the four keypad row lines and the latest converter sample.
//   Output channel (out_valid / out_stall): one result transaction per
//   input transaction, in order: column drive, detected key, entry status,
//   stored calibration offset and the displayed temperature.
//   Configuration: APB-style write/read of debounce_ticks (address 0) and
//   zero_code (address 4). pready is tied high. Write only while idle.
// Pipeline: input register, then result register
//   One transaction per cycle is sustained while out_stall is low: the
//   input register feeds the scan/entry logic, whose state and result
//   register update together.
// Reset
//   rst (synchronous) empties both stages, clears scan and entry state and
//   restores debounce_ticks = 20 and zero_code = 94.
// Stalls
//   While out_stall holds a result, the result register keeps it stable;
//   one more transaction waits in the input register, then in_stall rises.
module keypad_scan_offset_calibrator_core (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ksoc_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [ksoc_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [ksoc_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [ksoc_pkg::ROW_W-1:0]             row_lines,
  input  logic [ksoc_pkg::SAMPLE_W-1:0]          adc_sample,
  // output channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [2:0]                             column_drive,
  output logic                                   key_valid,
  output logic [ksoc_pkg::CODE_W-1:0]            key_code,
  output logic                                   entering,
  output logic [ksoc_pkg::VALUE_W-1:0]           entered_value,
  output logic [1:0]                             digit_count,
  output logic signed [ksoc_pkg::TEMP_W-1:0]     calibration_offset,
  output logic signed [ksoc_pkg::TEMP_W-1:0]     shown_temperature
);
  import ksoc_pkg::*;

  // Configuration registers
  logic [DEB_W-1:0]    debounce_ticks;
  logic [SAMPLE_W-1:0] zero_code;
  logic                cfg_write;

  // Input register
  logic                s1_valid;
  logic [ROW_W-1:0]    s1_rows;
  logic [SAMPLE_W-1:0] s1_sample;

  // Handshake control
  logic       out_free;
  logic       fire;
  logic       in_take;

  // Next result values from the logic between the two registers
  key_event_t               key_event;
  logic [2:0]               drive_next;
  logic                     entering_next;
  logic [VALUE_W-1:0]       value_next;
  logic [1:0]               count_next;
  logic signed [TEMP_W-1:0] offset_next;
  logic signed [TEMP_W-1:0] shown_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      zero_code      <= ZERO_CODE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_DEBOUNCE_TICKS: debounce_ticks <= pwdata[DEB_W-1:0];
        REG_ZERO_CODE:      zero_code      <= pwdata[SAMPLE_W-1:0];
        default:            debounce_ticks <= debounce_ticks;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEBOUNCE_TICKS: prdata = CFG_DATA_W'(debounce_ticks);
      REG_ZERO_CODE:      prdata = CFG_DATA_W'(zero_code);
      default:            prdata = '0;
    endcase
  end

  // Result register is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;
  assign fire     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_rows   <= row_lines;
      s1_sample <= adc_sample;
    end
  end

  ksoc_key_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .rows           (s1_rows),
    .debounce_ticks (debounce_ticks),
    .key_event      (key_event),
    .column_drive   (drive_next)
  );

  ksoc_entry u_entry (
    .clk                (clk),
    .rst                (rst),
    .fire               (fire),
    .key_event          (key_event),
    .adc_sample         (s1_sample),
    .zero_code          (zero_code),
    .entering           (entering_next),
    .entered_value      (value_next),
    .digit_count        (count_next),
    .calibration_offset (offset_next),
    .shown_temperature  (shown_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      column_drive       <= drive_next;
      key_valid          <= key_event.valid;
      key_code           <= key_event.code;
      entering           <= entering_next;
      entered_value      <= value_next;
      digit_count        <= count_next;
      calibration_offset <= offset_next;
      shown_temperature  <= shown_next;
    end
  end

`ifndef SYNTHESIS
  a_drive_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(column_drive))
    else $error("column drive not one-hot");
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with room in the pipeline");
  a_hash_closes_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_valid && key_code == KEY_HASH |-> !entering)
    else $error("hash left entry open");
  a_no_key_code_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_valid |-> key_code == KEY_NONE)
    else $error("key code set without a key");
`endif

endmodule

[rtl/ksoc_key_scan.sv]
// Column scan, debounce counter and row-to-key decode.
// Depends on ksoc_pkg.
module ksoc_key_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [ksoc_pkg::ROW_W-1:0]    rows,
  input  logic [ksoc_pkg::DEB_W-1:0]    debounce_ticks,
  output ksoc_pkg::key_event_t          key_event,
  output logic [2:0]                    column_drive
);
  import ksoc_pkg::*;

  logic [1:0]       column_index;
  logic [1:0]       column_index_next;
  logic [DEB_W-1:0] debounce_count;
  logic [DEB_W-1:0] debounce_count_next;
  logic             scanning;
  logic [1:0]       hit_row;

  assign scanning = (debounce_count == '0);

  // Lowest active row wins
  always_comb begin
    if (rows[0]) begin
      hit_row = 2'd0;
    end else if (rows[1]) begin
      hit_row = 2'd1;
    end else if (rows[2]) begin
      hit_row = 2'd2;
    end else begin
      hit_row = 2'd3;
    end
  end

  always_comb begin
    column_index_next   = column_index;
    debounce_count_next = debounce_count - DEB_W'(1);
    key_event.valid     = 1'b0;
    key_event.code      = KEY_NONE;
    if (scanning) begin
      column_index_next   = (column_index >= 2'd2) ? 2'd0 : column_index + 2'd1;
      debounce_count_next = '0;
      if (rows != '0) begin
        key_event.valid     = 1'b1;
        key_event.code      = key_lookup(hit_row, column_index_next);
        debounce_count_next = debounce_ticks;
      end
    end
  end

  always_comb begin
    case (column_index_next)
      2'd0:    column_drive = 3'b100;
      2'd1:    column_drive = 3'b010;
      default: column_drive = 3'b001;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index   <= '0;
      debounce_count <= '0;
    end else if (fire) begin
      column_index   <= column_index_next;
      debounce_count <= debounce_count_next;
    end
  end

`ifndef SYNTHESIS
  a_hit_reloads: assert property (@(posedge clk) disable iff (rst)
    fire && key_event.valid |=> debounce_count == $past(debounce_ticks))
    else $error("debounce counter not reloaded after key");
  a_no_scan_in_debounce: assert property (@(posedge clk) disable iff (rst)
    !scanning |-> !key_event.valid && column_index_next == column_index)
    else $error("scan advanced during debounce");
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    fire |=> column_index != 2'd3)
    else $error("column index out of range");
`endif

endmodule

[rtl/ksoc_entry.sv]
// Digit entry, calibration offset store and temperature reading.
// Depends on ksoc_pkg.
module ksoc_entry (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  ksoc_pkg::key_event_t                key_event,
  input  logic [ksoc_pkg::SAMPLE_W-1:0]       adc_sample,
  input  logic [ksoc_pkg::SAMPLE_W-1:0]       zero_code,
  output logic                                entering,
  output logic [ksoc_pkg::VALUE_W-1:0]        entered_value,
  output logic [1:0]                          digit_count,
  output logic signed [ksoc_pkg::TEMP_W-1:0]  calibration_offset,
  output logic signed [ksoc_pkg::TEMP_W-1:0]  shown_temperature
);
  import ksoc_pkg::*;

  logic                      entry_active;
  logic                      entry_active_next;
  logic [VALUE_W-1:0]        value_accum;
  logic [VALUE_W-1:0]        value_accum_next;
  logic [DIGIT_CNT_W-1:0]    digits_taken;
  logic [DIGIT_CNT_W-1:0]    digits_taken_next;
  logic signed [TEMP_W-1:0]  offset_reg;
  logic signed [TEMP_W-1:0]  offset_reg_next;

  logic signed [SAMPLE_W:0]  delta;
  logic signed [SAMPLE_W:0]  half;
  logic signed [TEMP_W-1:0]  half_ext;
  logic [13:0]               shifted_value;
  logic [DIGIT_CNT_W+1:0]    digits_wide;

  // Halve toward zero: bias negatives by one before the shift
  assign delta    = $signed({1'b0, adc_sample}) - $signed({1'b0, zero_code});
  assign half     = (delta + $signed({{SAMPLE_W{1'b0}}, delta[SAMPLE_W]})) >>> 1;
  assign half_ext = TEMP_W'(half);

  assign shifted_value = 14'(value_accum) * 14'd10 + 14'(key_event.code);

  always_comb begin
    entry_active_next = entry_active;
    value_accum_next  = value_accum;
    digits_taken_next = digits_taken;
    offset_reg_next   = offset_reg;
    if (key_event.valid) begin
      if (key_event.code == KEY_STAR) begin
        value_accum_next  = '0;
        digits_taken_next = '0;
        entry_active_next = 1'b1;
      end else if (key_event.code == KEY_HASH) begin
        entry_active_next = 1'b0;
        offset_reg_next   = $signed(TEMP_W'(value_accum)) - half_ext;
      end else if (entry_active && digits_taken < DIGIT_CNT_W'(MAX_DIGITS)) begin
        value_accum_next  = (shifted_value > 14'(VALUE_MAX)) ? VALUE_MAX
                                                             : shifted_value[VALUE_W-1:0];
        digits_taken_next = digits_taken + DIGIT_CNT_W'(1);
      end
    end
  end

  assign digits_wide        = (DIGIT_CNT_W+2)'(digits_taken_next);
  assign entering           = entry_active_next;
  assign entered_value      = value_accum_next;
  assign digit_count        = (digits_wide > (DIGIT_CNT_W+2)'(3)) ? 2'd3 : digits_wide[1:0];
  assign calibration_offset = offset_reg_next;
  assign shown_temperature  = offset_reg_next + half_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_active <= 1'b0;
      value_accum  <= '0;
      digits_taken <= '0;
      offset_reg   <= '0;
    end else if (fire) begin
      entry_active <= entry_active_next;
      value_accum  <= value_accum_next;
      digits_taken <= digits_taken_next;
      offset_reg   <= offset_reg_next;
    end
  end

`ifndef SYNTHESIS
  a_star_clears: assert property (@(posedge clk) disable iff (rst)
    fire && key_event.valid && key_event.code == KEY_STAR
    |=> entry_active && value_accum == '0 && digits_taken == '0)
    else $error("star did not open a clean entry");
  a_digits_bounded: assert property (@(posedge clk) disable iff (rst)
    digits_taken <= DIGIT_CNT_W'(MAX_DIGITS))
    else $error("digit counter past limit");
  a_offset_only_on_hash: assert property (@(posedge clk) disable iff (rst)
    fire && !(key_event.valid && key_event.code == KEY_HASH) |=> $stable(offset_reg))
    else $error("offset changed without hash");
`endif

endmodule
